### rtl/cscan_pkg.sv
// ----------------------------------------------------------------------------
// cscan_pkg
// shared types for the c-scan scheduler: datapath commands and status
// ----------------------------------------------------------------------------
package cscan_pkg;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SHIFT,
    DP_PLACE,
    DP_SKIP,
    DP_EMIT_UP,
    DP_EMIT_END,
    DP_EMIT_JUMP,
    DP_EMIT_LO
  } dp_cmd_e;

  typedef struct packed {
    logic add_op;
    logic full;
    logic pos_zero;
    logic entry_gt;
    logic up_done;
    logic entry_below;
    logic lo_empty;
    logic lo_last;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/cscan_if.sv
// ----------------------------------------------------------------------------
// cscan channel interfaces
// request, move and configuration channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface cscan_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] cylinder;

  modport source (output valid, output op, output cylinder, input ready);
  modport sink   (input valid, input op, input cylinder, output ready);
endinterface

interface cscan_move_if;
  logic        valid;
  logic        ready;
  logic [15:0] from_cylinder;
  logic [15:0] to_cylinder;
  logic [15:0] distance;
  logic        is_jump;
  logic [17:0] total_seek;
  logic        last;

  modport source (output valid, output from_cylinder, output to_cylinder,
                  output distance, output is_jump, output total_seek,
                  output last, input ready);
  modport sink   (input valid, input from_cylinder, input to_cylinder,
                  input distance, input is_jump, input total_seek,
                  input last, output ready);
endinterface

interface cscan_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/cscan_dp.sv
// ----------------------------------------------------------------------------
// cscan_dp
// request store, insertion walk, head/seek tracking and move output register
// ----------------------------------------------------------------------------
module cscan_dp #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cscan_cfg_if.sink           cfg_i,
  cscan_req_if.sink           req_i,
  cscan_move_if.source        move_o,
  input  cscan_pkg::dp_cmd_e  cmd_i,
  output cscan_pkg::dp_sts_t  sts_o
);

  localparam int unsigned CntW  = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned AddrW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  logic [16:0]     cfg_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] lo_cnt_q, lo_cnt_d;
  logic [15:0]     cyl_q, cyl_d;
  logic [15:0]     head_q, head_d;
  logic [17:0]     total_q, total_d;
  logic            out_valid_q, out_valid_d;
  logic [15:0]     from_q, to_q, dist_q;
  logic            jump_q, last_q;
  logic [17:0]     seek_q;

  logic [15:0]     mem_q [MAX_REQUESTS];
  logic [15:0]     rdata_q;
  logic            rd_en, wr_en;
  logic [CntW-1:0] rd_idx;
  logic [15:0]     wr_data;

  logic [15:0]     lastc, req_cyl, entry;
  logic            emit, out_free, lo_last;
  logic [15:0]     mv_to, mv_dist;
  logic            mv_jump, mv_last;
  logic [17:0]     mv_total;

  // last cylinder from the disk size, out-of-range sizes saturate
  always_comb begin
    if (cfg_q == 17'd0) begin
      lastc = 16'd0;
    end else if (cfg_q[16]) begin
      lastc = 16'hFFFF;
    end else begin
      lastc = cfg_q[15:0] - 16'd1;
    end
  end

  assign req_cyl  = (req_i.cylinder > lastc) ? lastc : req_i.cylinder;
  assign entry    = (rdata_q > lastc) ? lastc : rdata_q;
  assign out_free = !out_valid_q || move_o.ready;
  assign lo_last  = ((idx_q + CntW'(1)) == lo_cnt_q);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 17'h10000;
    end else if (cfg_i.valid) begin
      cfg_q <= cfg_i.data;
    end
  end

  // status to the controller
  always_comb begin
    sts_o.add_op      = !req_i.op;
    sts_o.full        = (count_q == CntW'(MAX_REQUESTS));
    sts_o.pos_zero    = (idx_q == '0);
    sts_o.entry_gt    = (rdata_q > cyl_q);
    sts_o.up_done     = (idx_q == count_q);
    sts_o.entry_below = (entry < cyl_q);
    sts_o.lo_empty    = (lo_cnt_q == '0);
    sts_o.lo_last     = lo_last;
    sts_o.out_free    = out_free;
  end

  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    lo_cnt_d = lo_cnt_q;
    cyl_d    = cyl_q;
    head_d   = head_q;
    total_d  = total_q;
    rd_en    = 1'b0;
    rd_idx   = idx_q + CntW'(1);
    wr_en    = 1'b0;
    wr_data  = cyl_q;
    emit     = 1'b0;
    mv_to    = entry;
    mv_jump  = 1'b0;
    mv_last  = 1'b0;
    unique case (cmd_i)
      cscan_pkg::DP_LOAD: begin
        cyl_d    = req_cyl;
        head_d   = req_cyl;
        total_d  = '0;
        lo_cnt_d = '0;
        rd_en    = 1'b1;
        if (!req_i.op) begin
          idx_d  = count_q;
          rd_idx = count_q - CntW'(1);
        end else begin
          idx_d  = '0;
          rd_idx = '0;
        end
      end
      cscan_pkg::DP_SHIFT: begin
        wr_en   = 1'b1;
        wr_data = rdata_q;
        idx_d   = idx_q - CntW'(1);
        rd_en   = 1'b1;
        rd_idx  = idx_q - CntW'(2);
      end
      cscan_pkg::DP_PLACE: begin
        wr_en   = 1'b1;
        count_d = count_q + CntW'(1);
      end
      cscan_pkg::DP_SKIP: begin
        idx_d    = idx_q + CntW'(1);
        lo_cnt_d = lo_cnt_q + CntW'(1);
        rd_en    = 1'b1;
      end
      cscan_pkg::DP_EMIT_UP: begin
        emit  = 1'b1;
        idx_d = idx_q + CntW'(1);
        rd_en = 1'b1;
      end
      cscan_pkg::DP_EMIT_END: begin
        emit  = 1'b1;
        mv_to = lastc;
      end
      cscan_pkg::DP_EMIT_JUMP: begin
        emit    = 1'b1;
        mv_to   = 16'd0;
        mv_jump = 1'b1;
        mv_last = (lo_cnt_q == '0);
        idx_d   = '0;
        rd_en   = 1'b1;
        rd_idx  = '0;
        if (lo_cnt_q == '0) begin
          count_d = '0;
        end
      end
      cscan_pkg::DP_EMIT_LO: begin
        emit    = 1'b1;
        mv_last = lo_last;
        idx_d   = idx_q + CntW'(1);
        rd_en   = 1'b1;
        if (lo_last) begin
          count_d = '0;
        end
      end
      default: begin
      end
    endcase
    mv_dist  = mv_jump ? lastc : (mv_to - head_q);
    mv_total = total_q + 18'(mv_dist);
    if (emit) begin
      head_d  = mv_to;
      total_d = mv_total;
    end
    out_valid_d = emit ? 1'b1 : (move_o.ready ? 1'b0 : out_valid_q);
  end

  // request store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx_q[AddrW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    lo_cnt_q <= lo_cnt_d;
    cyl_q    <= cyl_d;
    head_q   <= head_d;
    total_q  <= total_d;
    if (emit) begin
      from_q <= head_q;
      to_q   <= mv_to;
      dist_q <= mv_dist;
      jump_q <= mv_jump;
      last_q <= mv_last;
      seek_q <= mv_total;
    end
  end

  assign move_o.valid         = out_valid_q;
  assign move_o.from_cylinder = from_q;
  assign move_o.to_cylinder   = to_q;
  assign move_o.distance      = dist_q;
  assign move_o.is_jump       = jump_q;
  assign move_o.total_seek    = seek_q;
  assign move_o.last          = last_q;

endmodule

### rtl/cscan_ctrl.sv
// ----------------------------------------------------------------------------
// cscan_ctrl
// sequencer for request insertion and the c-scan service passes
// ----------------------------------------------------------------------------
module cscan_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  cscan_pkg::dp_sts_t  sts_i,
  output cscan_pkg::dp_cmd_e  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_UP,
    ST_END,
    ST_JUMP,
    ST_LO
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = cscan_pkg::DP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && ready_q) begin
          cmd_o = cscan_pkg::DP_LOAD;
          if (sts_i.add_op) begin
            state_d = sts_i.full ? ST_IDLE : ST_INS;
          end else begin
            state_d = ST_UP;
          end
        end
      end
      ST_INS: begin
        if (sts_i.pos_zero || !sts_i.entry_gt) begin
          cmd_o   = cscan_pkg::DP_PLACE;
          state_d = ST_IDLE;
        end else begin
          cmd_o = cscan_pkg::DP_SHIFT;
        end
      end
      ST_UP: begin
        if (sts_i.up_done) begin
          state_d = ST_END;
        end else if (sts_i.entry_below) begin
          cmd_o = cscan_pkg::DP_SKIP;
        end else if (sts_i.out_free) begin
          cmd_o = cscan_pkg::DP_EMIT_UP;
        end
      end
      ST_END: begin
        if (sts_i.out_free) begin
          cmd_o   = cscan_pkg::DP_EMIT_END;
          state_d = ST_JUMP;
        end
      end
      ST_JUMP: begin
        if (sts_i.out_free) begin
          cmd_o   = cscan_pkg::DP_EMIT_JUMP;
          state_d = sts_i.lo_empty ? ST_IDLE : ST_LO;
        end
      end
      ST_LO: begin
        if (sts_i.out_free) begin
          cmd_o = cscan_pkg::DP_EMIT_LO;
          if (sts_i.lo_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign req_ready_o = ready_q;

endmodule

### rtl/cscan_disk_scheduler.sv
// ----------------------------------------------------------------------------
// cscan_disk_scheduler
// An add request loads the new cylinder and then walks the sorted store from
// the top, shifting up each stored request above the new one, one entry per
// cycle through the single write and registered read port of the store, and
// then places the new request. An add to a full store is dropped. A run
// request makes an upward pass that visits every stored entry at one entry a
// cycle while the output register is free (entries below the head are skipped
// and never wait), then finishes with a step that emits no move; the end move
// and the wrap jump follow, and the lower pass visits only the stored requests
// below the head. Every move waits for the output register to be free.
// Requests are taken only while the sequencer is idle; a finished move may
// still sit in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module cscan_disk_scheduler #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cscan_cfg_if.sink     cfg_i,
  cscan_req_if.sink     req_i,
  cscan_move_if.source  move_o
);

  cscan_pkg::dp_cmd_e cmd;
  cscan_pkg::dp_sts_t sts;
  logic               req_ready;

  assign req_i.ready = req_ready;

  cscan_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cscan_dp #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .req_i  (req_i),
    .move_o (move_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
